>>> hw/rtl/mvhe_pkg.sv
// Shared types and constants for the MPEG video header extractor.
`default_nettype none

package mvhe_pkg;

    localparam int unsigned HDR_DEPTH = 7;

    localparam logic [23:0] START_PREFIX  = 24'h000001;
    localparam logic [7:0]  CODE_PICTURE  = 8'h00;
    localparam logic [7:0]  CODE_SEQUENCE = 8'hB3;
    localparam logic [7:0]  CODE_EXTENSION = 8'hB5;
    localparam logic [7:0]  CODE_SLICE_FIRST = 8'h01;
    localparam logic [7:0]  CODE_SLICE_LAST  = 8'hAF;

    localparam logic [3:0]  EXT_ID_SEQUENCE = 4'h1;
    localparam logic [3:0]  EXT_ID_PICTURE  = 4'h8;

    localparam logic [17:0] MPEG1_RATE_VBR = 18'h3FFFF;
    localparam logic [15:0] VBV_VBR_MARK   = 16'hFFFF;

    localparam logic [1:0]  CHROMA_NONE = 2'd0;
    localparam logic [1:0]  CHROMA_420  = 2'd1;

    localparam logic [1:0]  ORDER_PROGRESSIVE = 2'd1;
    localparam logic [1:0]  ORDER_TOP_FIRST   = 2'd2;
    localparam logic [1:0]  ORDER_BOTTOM_FIRST = 2'd3;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_PIC  = 2'd1,
        KIND_SEQ  = 2'd2,
        KIND_EXT  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [13:0] frame_width;
        logic [13:0] frame_height;
        logic [2:0]  picture_type;
        logic [2:0]  repeat_count;
        logic [1:0]  order_kind;
        logic [1:0]  chroma_kind;
        logic [3:0]  rate_index;
        logic [1:0]  rate_ext_num;
        logic [4:0]  rate_ext_den;
        logic        is_mpeg2;
        logic [29:0] bit_rate_units;
        logic        bit_rate_valid;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/mvhe_parser.sv
// Start code scan, header capture and per-frame summary, one byte per step.
`default_nettype none

module mvhe_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_frame_end,
    output logic                  o_result_valid,
    output mvhe_pkg::t_result     o_result
);

    logic [31:0]         r_win,    n_win;
    mvhe_pkg::t_kind     r_kind,   n_kind;
    logic [2:0]          r_count,  n_count;
    logic                r_slice,  n_slice;
    logic [13:0]         r_width,  n_width;
    logic [13:0]         r_height, n_height;
    logic                r_prog,   n_prog;
    logic [2:0]          r_type,   n_type;
    logic [2:0]          r_repeat, n_repeat;
    logic [1:0]          r_order,  n_order;
    logic [1:0]          r_chroma, n_chroma;
    logic [10:0]         r_rate,   n_rate;
    logic                r_mpeg2,  n_mpeg2;
    logic [29:0]         r_rbits,  n_rbits;
    logic [15:0]         r_vbv,    n_vbv;
    logic [7:0]          r_hdr [mvhe_pkg::HDR_DEPTH];
    logic                n_hdr_we;

    logic [7:0]          w_hv [mvhe_pkg::HDR_DEPTH];
    logic [31:0]         w_win;
    logic [2:0]          w_cnt;
    logic [3:0]          w_ext_id;
    logic                w_tff;
    logic                w_rff;
    logic                w_pf;
    logic [1:0]          w_cf;

    // header view including the byte being captured now
    always_comb begin
        for (int i = 0; i < mvhe_pkg::HDR_DEPTH; i++) begin
            w_hv[i] = (r_count == 3'(i)) ? i_data_byte : r_hdr[i];
        end
    end

    assign w_win    = {r_win[23:0], i_data_byte};
    assign w_cnt    = r_count + 3'd1;
    assign w_ext_id = w_hv[0][7:4];
    assign w_tff    = w_hv[3][7];
    assign w_rff    = w_hv[3][1];
    assign w_pf     = w_hv[4][7];
    assign w_cf     = w_hv[1][2:1];

    always_comb begin
        n_win    = r_win;
        n_kind   = r_kind;
        n_count  = r_count;
        n_slice  = r_slice;
        n_width  = r_width;
        n_height = r_height;
        n_prog   = r_prog;
        n_type   = r_type;
        n_repeat = r_repeat;
        n_order  = r_order;
        n_chroma = r_chroma;
        n_rate   = r_rate;
        n_mpeg2  = r_mpeg2;
        n_rbits  = r_rbits;
        n_vbv    = r_vbv;
        n_hdr_we = 1'b0;

        if (i_step && !r_slice) begin
            n_win = w_win;
            if (w_win[31:8] == mvhe_pkg::START_PREFIX) begin
                n_win   = '1;
                n_count = 3'd0;
                case (i_data_byte)
                    mvhe_pkg::CODE_PICTURE:   n_kind = mvhe_pkg::KIND_PIC;
                    mvhe_pkg::CODE_SEQUENCE:  n_kind = mvhe_pkg::KIND_SEQ;
                    mvhe_pkg::CODE_EXTENSION: n_kind = mvhe_pkg::KIND_EXT;
                    default: begin
                        n_kind = mvhe_pkg::KIND_NONE;
                        if (i_data_byte inside
                            {[mvhe_pkg::CODE_SLICE_FIRST:mvhe_pkg::CODE_SLICE_LAST]}) begin
                            n_slice = 1'b1;
                        end
                    end
                endcase
            end else if (r_kind != mvhe_pkg::KIND_NONE &&
                         r_count < 3'(mvhe_pkg::HDR_DEPTH)) begin
                n_hdr_we = 1'b1;
                n_count  = w_cnt;
                case (r_kind)
                    mvhe_pkg::KIND_PIC: begin
                        if (w_cnt == 3'd2) begin
                            n_type = w_hv[1][5:3];
                        end
                        if (w_cnt == 3'd4) begin
                            n_vbv  = {w_hv[1][2:0], w_hv[2], w_hv[3][7:3]};
                            n_kind = mvhe_pkg::KIND_NONE;
                        end
                    end
                    mvhe_pkg::KIND_SEQ: begin
                        if (w_cnt == 3'd7) begin
                            n_width  = {2'b00, w_hv[0], w_hv[1][7:4]};
                            n_height = {2'b00, w_hv[1][3:0], w_hv[2]};
                            n_chroma = mvhe_pkg::CHROMA_420;
                            n_rate   = {w_hv[3][3:0], 7'd0};
                            n_rbits  = {12'd0, w_hv[4], w_hv[5], w_hv[6][7:6]};
                            n_mpeg2  = 1'b0;
                            n_kind   = mvhe_pkg::KIND_NONE;
                        end
                    end
                    mvhe_pkg::KIND_EXT: begin
                        if (w_ext_id != mvhe_pkg::EXT_ID_SEQUENCE &&
                            w_ext_id != mvhe_pkg::EXT_ID_PICTURE) begin
                            n_kind = mvhe_pkg::KIND_NONE;
                        end else if (w_ext_id == mvhe_pkg::EXT_ID_PICTURE &&
                                     w_cnt == 3'd5) begin
                            n_repeat = 3'd1;
                            if (w_rff) begin
                                if (r_prog) begin
                                    n_repeat = w_tff ? 3'd5 : 3'd3;
                                end else if (w_pf) begin
                                    n_repeat = 3'd2;
                                end
                            end
                            if (!r_prog && !w_pf) begin
                                n_order = w_tff ? mvhe_pkg::ORDER_TOP_FIRST
                                                : mvhe_pkg::ORDER_BOTTOM_FIRST;
                            end else begin
                                n_order = mvhe_pkg::ORDER_PROGRESSIVE;
                            end
                            n_kind = mvhe_pkg::KIND_NONE;
                        end else if (w_ext_id == mvhe_pkg::EXT_ID_SEQUENCE &&
                                     w_cnt == 3'd6) begin
                            n_prog = w_hv[1][3];
                            if (w_cf != mvhe_pkg::CHROMA_NONE) begin
                                n_chroma = w_cf;
                            end
                            n_width  = {w_hv[1][0], w_hv[2][7], r_width[11:0]};
                            n_height = {w_hv[2][6:5], r_height[11:0]};
                            n_rbits  = {w_hv[2][4:0], w_hv[3][7:1], r_rbits[17:0]};
                            n_rate   = {r_rate[10:7], w_hv[5][6:5], w_hv[5][4:0]};
                            n_mpeg2  = 1'b1;
                            n_kind   = mvhe_pkg::KIND_NONE;
                        end
                    end
                    default: ;
                endcase
            end
        end

        o_result_valid          = i_step && i_frame_end;
        o_result.frame_width    = n_width;
        o_result.frame_height   = n_height;
        o_result.picture_type   = n_type;
        o_result.repeat_count   = n_repeat;
        o_result.order_kind     = n_order;
        o_result.chroma_kind    = n_chroma;
        o_result.rate_index     = n_rate[10:7];
        o_result.rate_ext_num   = n_rate[6:5];
        o_result.rate_ext_den   = n_rate[4:0];
        o_result.is_mpeg2       = n_mpeg2;
        o_result.bit_rate_units = n_rbits;
        o_result.bit_rate_valid = (n_rbits != 30'd0) &&
            ((!n_mpeg2 && n_rbits != {12'd0, mvhe_pkg::MPEG1_RATE_VBR}) ||
             n_vbv != mvhe_pkg::VBV_VBR_MARK);

        // per-frame state returns to reset after the summary
        if (i_step && i_frame_end) begin
            n_win    = '1;
            n_kind   = mvhe_pkg::KIND_NONE;
            n_count  = 3'd0;
            n_slice  = 1'b0;
            n_repeat = 3'd0;
            n_chroma = mvhe_pkg::CHROMA_NONE;
            n_rbits  = 30'd0;
            n_vbv    = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= '1;
            r_kind   <= mvhe_pkg::KIND_NONE;
            r_count  <= 3'd0;
            r_slice  <= 1'b0;
            r_width  <= 14'd0;
            r_height <= 14'd0;
            r_prog   <= 1'b0;
            r_type   <= 3'd0;
            r_repeat <= 3'd0;
            r_order  <= 2'd0;
            r_chroma <= mvhe_pkg::CHROMA_NONE;
            r_rate   <= 11'd0;
            r_mpeg2  <= 1'b0;
            r_rbits  <= 30'd0;
            r_vbv    <= 16'd0;
        end else begin
            r_win    <= n_win;
            r_kind   <= n_kind;
            r_count  <= n_count;
            r_slice  <= n_slice;
            r_width  <= n_width;
            r_height <= n_height;
            r_prog   <= n_prog;
            r_type   <= n_type;
            r_repeat <= n_repeat;
            r_order  <= n_order;
            r_chroma <= n_chroma;
            r_rate   <= n_rate;
            r_mpeg2  <= n_mpeg2;
            r_rbits  <= n_rbits;
            r_vbv    <= n_vbv;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < mvhe_pkg::HDR_DEPTH; i++) begin
            if (n_hdr_we && r_count == 3'(i)) begin
                r_hdr[i] <= i_data_byte;
            end
        end
    end

`ifndef ASSERT_OFF
    a_slice_no_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slice |-> r_kind == mvhe_pkg::KIND_NONE)
        else $error("capture running after slice start");

    a_pic_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kind == mvhe_pkg::KIND_PIC) |-> r_count < 3'd4)
        else $error("picture header capture overran");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_frame_end) |=> (r_win == '1 && !r_slice && r_count == 3'd0))
        else $error("frame state not cleared after frame end");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/mpeg_video_header_extractor_core.sv
// Top level of the MPEG video header extractor.
// Input channel: one stream byte per transaction (i_data_byte), with
//   i_frame_end marking the last byte of a frame.
// Output channel: one summary transaction per frame, holding size, picture
//   type, repeat count, field order, chroma format, rate fields, MPEG-2 flag
//   and the qualified bit rate.
// Throughput: one byte per cycle while no frame-end byte waits on the output;
//   per-byte header state is updated from the input register into the parser.
// Summary path: a frame's last byte is parsed into the output register once
//   that is free, or as soon as an earlier waiting summary has been taken.
// Reset: control state and parsed header fields clear; the first frame starts
//   with no header seen.
// Receiver stall: a waiting summary holds in the output register; bytes
//   that do not end a frame keep flowing, and a frame-end byte waits in the
//   input register until the output register is free.
`default_nettype none

module mpeg_video_header_extractor_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_frame_end,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [13:0]      o_frame_width,
    output logic [13:0]      o_frame_height,
    output logic [2:0]       o_picture_type,
    output logic [2:0]       o_repeat_count,
    output logic [1:0]       o_field_order,
    output logic [1:0]       o_chroma_kind,
    output logic [3:0]       o_rate_index,
    output logic [1:0]       o_rate_ext_num,
    output logic [4:0]       o_rate_ext_den,
    output logic             o_is_mpeg2,
    output logic [29:0]      o_bit_rate_units,
    output logic             o_bit_rate_valid
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_last;
    logic                r_out_valid;
    mvhe_pkg::t_result   r_res;

    logic                w_step;
    logic                w_res_valid;
    mvhe_pkg::t_result   w_res;

    assign w_step  = r_in_valid && (!r_in_last || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_step;

    mvhe_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_data_byte    (r_in_byte),
        .i_frame_end    (r_in_last),
        .o_result_valid (w_res_valid),
        .o_result       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_frame_end;
        end
        if (w_res_valid) begin
            r_res <= w_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_frame_width    = r_res.frame_width;
    assign o_frame_height   = r_res.frame_height;
    assign o_picture_type   = r_res.picture_type;
    assign o_repeat_count   = r_res.repeat_count;
    assign o_field_order    = r_res.order_kind;
    assign o_chroma_kind    = r_res.chroma_kind;
    assign o_rate_index     = r_res.rate_index;
    assign o_rate_ext_num   = r_res.rate_ext_num;
    assign o_rate_ext_den   = r_res.rate_ext_den;
    assign o_is_mpeg2       = r_res.is_mpeg2;
    assign o_bit_rate_units = r_res.bit_rate_units;
    assign o_bit_rate_valid = r_res.bit_rate_valid;

`ifndef ASSERT_OFF
    a_summary_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in_last) |=> r_out_valid)
        else $error("frame end processed without a summary");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_ready)
        else $error("input stage empty but not ready");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !w_res_valid)
        else $error("pending summary overwritten");
`endif

endmodule

`default_nettype wire

>>> tb/tb_mpeg_video_header_extractor_core.sv
// Self-checking testbench for the MPEG video header extractor core.
`timescale 1ns / 100ps

module tb_mpeg_video_header_extractor_core;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_stream_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_frame_end = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [13:0] o_frame_width;
    logic [13:0] o_frame_height;
    logic [2:0]  o_picture_type;
    logic [2:0]  o_repeat_count;
    logic [1:0]  o_field_order;
    logic [1:0]  o_chroma_kind;
    logic [3:0]  o_rate_index;
    logic [1:0]  o_rate_ext_num;
    logic [4:0]  o_rate_ext_den;
    logic        o_is_mpeg2;
    logic [29:0] o_bit_rate_units;
    logic        o_bit_rate_valid;

    mpeg_video_header_extractor_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_frame_end      (i_frame_end),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_frame_width    (o_frame_width),
        .o_frame_height   (o_frame_height),
        .o_picture_type   (o_picture_type),
        .o_repeat_count   (o_repeat_count),
        .o_field_order    (o_field_order),
        .o_chroma_kind    (o_chroma_kind),
        .o_rate_index     (o_rate_index),
        .o_rate_ext_num   (o_rate_ext_num),
        .o_rate_ext_den   (o_rate_ext_den),
        .o_is_mpeg2       (o_is_mpeg2),
        .o_bit_rate_units (o_bit_rate_units),
        .o_bit_rate_valid (o_bit_rate_valid)
    );

    t_stream_byte      stream_q[$];
    mvhe_pkg::t_result summaries_due[$];
    logic [7:0]        frame_buf[$];
    t_stream_byte      drive_item;
    mvhe_pkg::t_result want_summary;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int cycle_count = 0;
    int bytes_made = 0;
    int frames_made = 0;

    // parser state
    logic [31:0]     code_window = '1;
    mvhe_pkg::t_kind hdr_kind = mvhe_pkg::KIND_NONE;
    int              hdr_count = 0;
    logic [7:0]      hdr_bytes[mvhe_pkg::HDR_DEPTH];
    logic            slice_seen = 1'b0;
    logic [13:0]     sz_width = '0;
    logic [13:0]     sz_height = '0;
    logic            prog_seq = 1'b0;
    logic [2:0]      pic_type = '0;
    logic [2:0]      repeat_cnt = '0;
    logic [1:0]      field_ord = '0;
    logic [1:0]      chroma_fmt = mvhe_pkg::CHROMA_NONE;
    logic [10:0]     rate_code = '0;
    logic            mpeg2_seen = 1'b0;
    logic [29:0]     rate_acc = '0;
    logic [15:0]     vbv_val = '0;

    task automatic parse_byte(input logic [7:0] b, input logic fe);
        logic [3:0]        ext_id;
        logic              tff;
        logic              rff;
        logic              pf;
        logic [1:0]        cf;
        mvhe_pkg::t_result s;
        if (!slice_seen) begin
            code_window = {code_window[23:0], b};
            if (code_window[31:8] == mvhe_pkg::START_PREFIX) begin
                case (code_window[7:0])
                    mvhe_pkg::CODE_PICTURE:   hdr_kind = mvhe_pkg::KIND_PIC;
                    mvhe_pkg::CODE_SEQUENCE:  hdr_kind = mvhe_pkg::KIND_SEQ;
                    mvhe_pkg::CODE_EXTENSION: hdr_kind = mvhe_pkg::KIND_EXT;
                    default: begin
                        hdr_kind = mvhe_pkg::KIND_NONE;
                        if (code_window[7:0] >= mvhe_pkg::CODE_SLICE_FIRST &&
                            code_window[7:0] <= mvhe_pkg::CODE_SLICE_LAST)
                            slice_seen = 1'b1;
                    end
                endcase
                code_window = '1;
                hdr_count = 0;
            end else if (hdr_kind != mvhe_pkg::KIND_NONE &&
                         hdr_count < mvhe_pkg::HDR_DEPTH) begin
                hdr_bytes[hdr_count] = b;
                hdr_count++;
                if (hdr_kind == mvhe_pkg::KIND_PIC) begin
                    if (hdr_count == 2)
                        pic_type = hdr_bytes[1][5:3];
                    if (hdr_count == 4) begin
                        vbv_val = {hdr_bytes[1][2:0], hdr_bytes[2], hdr_bytes[3][7:3]};
                        hdr_kind = mvhe_pkg::KIND_NONE;
                    end
                end else if (hdr_kind == mvhe_pkg::KIND_SEQ) begin
                    if (hdr_count == 7) begin
                        sz_width = {2'b00, hdr_bytes[0], hdr_bytes[1][7:4]};
                        sz_height = {2'b00, hdr_bytes[1][3:0], hdr_bytes[2]};
                        chroma_fmt = mvhe_pkg::CHROMA_420;
                        rate_code = {hdr_bytes[3][3:0], 7'd0};
                        rate_acc = {12'd0, hdr_bytes[4], hdr_bytes[5], hdr_bytes[6][7:6]};
                        mpeg2_seen = 1'b0;
                        hdr_kind = mvhe_pkg::KIND_NONE;
                    end
                end else begin
                    ext_id = hdr_bytes[0][7:4];
                    if (ext_id != mvhe_pkg::EXT_ID_SEQUENCE &&
                        ext_id != mvhe_pkg::EXT_ID_PICTURE) begin
                        hdr_kind = mvhe_pkg::KIND_NONE;
                    end else if (ext_id == mvhe_pkg::EXT_ID_PICTURE && hdr_count == 5) begin
                        tff = hdr_bytes[3][7];
                        rff = hdr_bytes[3][1];
                        pf = hdr_bytes[4][7];
                        repeat_cnt = 3'd1;
                        if (rff) begin
                            if (prog_seq)
                                repeat_cnt = tff ? 3'd5 : 3'd3;
                            else if (pf)
                                repeat_cnt = 3'd2;
                        end
                        if (!prog_seq && !pf)
                            field_ord = tff ? mvhe_pkg::ORDER_TOP_FIRST
                                            : mvhe_pkg::ORDER_BOTTOM_FIRST;
                        else
                            field_ord = mvhe_pkg::ORDER_PROGRESSIVE;
                        hdr_kind = mvhe_pkg::KIND_NONE;
                    end else if (ext_id == mvhe_pkg::EXT_ID_SEQUENCE && hdr_count == 6) begin
                        cf = hdr_bytes[1][2:1];
                        prog_seq = hdr_bytes[1][3];
                        if (cf != mvhe_pkg::CHROMA_NONE)
                            chroma_fmt = cf;
                        sz_width = {hdr_bytes[1][0], hdr_bytes[2][7], sz_width[11:0]};
                        sz_height = {hdr_bytes[2][6:5], sz_height[11:0]};
                        rate_acc = {hdr_bytes[2][4:0], hdr_bytes[3][7:1], rate_acc[17:0]};
                        rate_code = {rate_code[10:7], hdr_bytes[5][6:5], hdr_bytes[5][4:0]};
                        mpeg2_seen = 1'b1;
                        hdr_kind = mvhe_pkg::KIND_NONE;
                    end
                end
            end
        end
        if (fe) begin
            s.frame_width = sz_width;
            s.frame_height = sz_height;
            s.picture_type = pic_type;
            s.repeat_count = repeat_cnt;
            s.order_kind = field_ord;
            s.chroma_kind = chroma_fmt;
            s.rate_index = rate_code[10:7];
            s.rate_ext_num = rate_code[6:5];
            s.rate_ext_den = rate_code[4:0];
            s.is_mpeg2 = mpeg2_seen;
            s.bit_rate_units = rate_acc;
            s.bit_rate_valid = (rate_acc != '0) &&
                ((!mpeg2_seen && rate_acc != {12'd0, mvhe_pkg::MPEG1_RATE_VBR}) ||
                 vbv_val != mvhe_pkg::VBV_VBR_MARK);
            summaries_due.push_back(s);
            code_window = '1;
            hdr_kind = mvhe_pkg::KIND_NONE;
            hdr_count = 0;
            slice_seen = 1'b0;
            repeat_cnt = '0;
            chroma_fmt = mvhe_pkg::CHROMA_NONE;
            rate_acc = '0;
            vbv_val = '0;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // stream generation
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(5))
            0, 1: return 8'h00;
            2: return 8'h01;
            3: begin
                case ($urandom_range(3))
                    0: return mvhe_pkg::CODE_SEQUENCE;
                    1: return mvhe_pkg::CODE_EXTENSION;
                    2: return mvhe_pkg::CODE_PICTURE;
                    default: return 8'($urandom_range(255, 8'hB0));
                endcase
            end
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic add_start(input logic [7:0] code);
        frame_buf.push_back(mvhe_pkg::START_PREFIX[23:16]);
        frame_buf.push_back(mvhe_pkg::START_PREFIX[15:8]);
        frame_buf.push_back(mvhe_pkg::START_PREFIX[7:0]);
        frame_buf.push_back(code);
    endtask

    // header body, cut short now and then so that the next start code interrupts it
    task automatic add_body(input logic [7:0] body[7], input int len);
        int n;
        n = len;
        if ($urandom_range(9) == 0)
            n = $urandom_range(len - 1, 0);
        for (int k = 0; k < n; k++)
            frame_buf.push_back(body[k]);
    endtask

    task automatic add_sequence_header();
        logic [7:0] body[7];
        foreach (body[k])
            body[k] = 8'($urandom_range(255));
        case ($urandom_range(3))
            0: begin
                body[4] = 8'hFF;
                body[5] = 8'hFF;
                body[6] = body[6] | 8'hC0;
            end
            1: begin
                body[4] = 8'h00;
                body[5] = 8'h00;
                body[6] = body[6] & 8'h3F;
            end
            default: ;
        endcase
        add_start(mvhe_pkg::CODE_SEQUENCE);
        add_body(body, 7);
    endtask

    task automatic add_sequence_ext();
        logic [7:0] body[7];
        foreach (body[k])
            body[k] = 8'($urandom_range(255));
        if ($urandom_range(9) != 0)
            body[0][7:4] = mvhe_pkg::EXT_ID_SEQUENCE;
        add_start(mvhe_pkg::CODE_EXTENSION);
        add_body(body, 6);
    endtask

    task automatic add_picture_header();
        logic [7:0] body[7];
        foreach (body[k])
            body[k] = 8'($urandom_range(255));
        if ($urandom_range(3) == 0) begin
            body[1] = body[1] | 8'h07;
            body[2] = 8'hFF;
            body[3] = body[3] | 8'hF8;
        end
        add_start(mvhe_pkg::CODE_PICTURE);
        add_body(body, 4);
    endtask

    task automatic add_picture_ext();
        logic [7:0] body[7];
        foreach (body[k])
            body[k] = 8'($urandom_range(255));
        if ($urandom_range(9) != 0)
            body[0][7:4] = mvhe_pkg::EXT_ID_PICTURE;
        add_start(mvhe_pkg::CODE_EXTENSION);
        add_body(body, 5);
    endtask

    task automatic emit_frame();
        t_stream_byte item;
        if (frame_buf.size() == 0)
            frame_buf.push_back(8'($urandom_range(255)));
        foreach (frame_buf[k]) begin
            item.data = frame_buf[k];
            item.last = (k == frame_buf.size() - 1);
            stream_q.push_back(item);
        end
        bytes_made += frame_buf.size();
        frames_made++;
        frame_buf.delete();
    endtask

    task automatic random_frame();
        int cut;
        if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(12, 1))
                frame_buf.push_back(noise_byte());
        end else begin
            if ($urandom_range(9) < 6) begin
                add_sequence_header();
                if ($urandom_range(9) < 7)
                    add_sequence_ext();
            end
            if ($urandom_range(9) < 2)
                add_start(8'($urandom_range(255, 8'hB6)));
            if ($urandom_range(9) < 9) begin
                add_picture_header();
                if ($urandom_range(9) < 7)
                    add_picture_ext();
            end
            if ($urandom_range(9) < 8) begin
                add_start(8'($urandom_range(mvhe_pkg::CODE_SLICE_LAST,
                                            mvhe_pkg::CODE_SLICE_FIRST)));
                repeat ($urandom_range(6))
                    frame_buf.push_back(noise_byte());
            end
            if (frame_buf.size() > 1 && $urandom_range(9) < 2) begin
                cut = $urandom_range(frame_buf.size() - 1, 1);
                frame_buf = frame_buf[0:cut-1];
            end
        end
        emit_frame();
    endtask

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("mpeg_video_header_extractor_core regression: fail");
            $finish;
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                parse_byte(i_data_byte, i_frame_end);
            if (!i_valid || o_ready) begin
                if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drive_item = stream_q.pop_front();
                    i_valid <= 1'b1;
                    i_data_byte <= drive_item.data;
                    i_frame_end <= drive_item.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (summaries_due.size() == 0) begin
                    $error("unexpected summary transaction");
                    error_count++;
                end else begin
                    want_summary = summaries_due.pop_front();
                    check_field("frame_width", want_summary.frame_width, o_frame_width);
                    check_field("frame_height", want_summary.frame_height, o_frame_height);
                    check_field("picture_type", want_summary.picture_type, o_picture_type);
                    check_field("repeat_count", want_summary.repeat_count, o_repeat_count);
                    check_field("field_order", want_summary.order_kind, o_field_order);
                    check_field("chroma_kind", want_summary.chroma_kind, o_chroma_kind);
                    check_field("rate_index", want_summary.rate_index, o_rate_index);
                    check_field("rate_ext_num", want_summary.rate_ext_num, o_rate_ext_num);
                    check_field("rate_ext_den", want_summary.rate_ext_den, o_rate_ext_den);
                    check_field("is_mpeg2", want_summary.is_mpeg2, o_is_mpeg2);
                    check_field("bit_rate_units", want_summary.bit_rate_units,
                                o_bit_rate_units);
                    check_field("bit_rate_valid", want_summary.bit_rate_valid,
                                o_bit_rate_valid);
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int goal_bytes;
        int goal_frames;

        // full-range sequence header, summary on the committing byte
        frame_buf = '{8'h00, 8'h00, 8'h01, 8'hB3, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'hFF, 8'hFF, 8'hFF};
        emit_frame();
        // sequence header cut by an extension code, unknown extension id,
        // slice code, then bytes ignored up to frame end
        frame_buf = '{8'h00, 8'h00, 8'h01, 8'hB3, 8'h12, 8'h00, 8'h00, 8'h01,
                      8'hB5, 8'h7F, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h00,
                      8'h01, 8'hB3, 8'h80};
        emit_frame();
        // picture header too short at frame end
        frame_buf = '{8'h00, 8'h00, 8'h01, 8'h00, 8'hFF};
        emit_frame();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            goal_bytes = bytes_made + 135;
            goal_frames = frames_made + 5;
            while (bytes_made < goal_bytes || frames_made < goal_frames)
                random_frame();
            while (stream_q.size() != 0 || i_valid)
                @(negedge i_clk);
        end

        while (summaries_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("mpeg_video_header_extractor_core regression: pass");
        else
            $display("mpeg_video_header_extractor_core regression: fail");
        $finish;
    end

endmodule
